FILE: design/rectangle_outline_fill_raster_defines.svh
// ---------------------------------------------------------------------------
// Rectangle raster assertion macros
// Shared concurrent assertion forms for the rectangle raster checkers.
// ---------------------------------------------------------------------------
`ifndef RECTANGLE_OUTLINE_FILL_RASTER_DEFINES_SVH
`define RECTANGLE_OUTLINE_FILL_RASTER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define ROFR_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rofr assertion failed");

// next-cycle implication, disabled in reset
`define ROFR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rofr assertion failed");

`endif

FILE: design/rofr_pkg.sv
// ---------------------------------------------------------------------------
// rofr_pkg
// Shared constants, codes and types of the rectangle raster block.
// ---------------------------------------------------------------------------
package rofr_pkg;

	localparam int MAX_COLUMNS = 256;
	localparam int MAX_ROWS    = 256;
	localparam int COL_W       = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int ROW_W       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int ADDR_W      = COL_W + ROW_W;
	localparam int MEM_DEPTH   = 1 << ADDR_W;

	localparam int FIELD_W  = 20;
	localparam int COORD_W  = 22;
	localparam int FRAC_W   = 8;
	localparam int CANVAS_W = 9;
	localparam int CHAR_W   = 8;
	localparam int PIX_W    = 8;
	localparam int CMP_W    = 16;

	localparam logic signed [COORD_W-1:0] ONE_Q = COORD_W'(1 << FRAC_W);

	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	localparam logic [1:0] REG_CANVAS_W = 2'd0;
	localparam logic [1:0] REG_CANVAS_H = 2'd1;
	localparam logic [1:0] REG_BG_CHAR  = 2'd2;

	localparam logic [CANVAS_W-1:0] RST_CANVAS_W = CANVAS_W'(256);
	localparam logic [CANVAS_W-1:0] RST_CANVAS_H = CANVAS_W'(256);
	localparam logic [CHAR_W-1:0]   RST_BG_CHAR  = CHAR_W'(32);

	localparam logic [1:0] MODE_CLEAR = 2'd0;
	localparam logic [1:0] MODE_DRAW  = 2'd1;
	localparam logic [1:0] MODE_READ  = 2'd2;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_BAD_SIZE = 2'd1;
	localparam logic [1:0] STAT_OUTSIDE  = 2'd2;

	localparam logic [1:0] OP_NONE  = 2'd0;
	localparam logic [1:0] OP_CLEAR = 2'd1;
	localparam logic [1:0] OP_DRAW  = 2'd2;
	localparam logic [1:0] OP_READ  = 2'd3;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [COL_W-1:0]  last_col;
		logic [ROW_W-1:0]  last_row;
		logic [CHAR_W-1:0] bg_char;
	} canvas_cfg_t;

	typedef struct packed {
		logic [1:0]                op;
		logic [1:0]                status;
		logic signed [COORD_W-1:0] x_lo;
		logic signed [COORD_W-1:0] x_hi;
		logic signed [COORD_W-1:0] x_lo_in;
		logic signed [COORD_W-1:0] x_hi_in;
		logic signed [COORD_W-1:0] y_lo;
		logic signed [COORD_W-1:0] y_hi;
		logic signed [COORD_W-1:0] y_lo_in;
		logic signed [COORD_W-1:0] y_hi_in;
		logic                      full;
		logic [CHAR_W-1:0]         paint;
		logic [COL_W-1:0]          rd_x;
		logic [ROW_W-1:0]          rd_y;
	} rofr_cmd_t;

	// last index in use; zero acts as one, oversize acts as the maximum
	function automatic logic [CMP_W-1:0] dim_last(input logic [CANVAS_W-1:0] v,
			input int maxv);
		logic [CMP_W-1:0] r;
		if (v == '0)
			r = '0;
		else if (32'(v) > 32'(maxv))
			r = CMP_W'(maxv - 1);
		else
			r = CMP_W'(32'(v) - 32'd1);
		return r;
	endfunction

endpackage

FILE: design/rectangle_outline_fill_raster.sv
// ---------------------------------------------------------------------------
// rectangle_outline_fill_raster
// Rectangle outline / fill raster into an 8-bit character frame store.
// ---------------------------------------------------------------------------
// Usage:
//  Commands enter on start while busy is low; mode selects clear, draw or
//  read. Rectangle edges and sizes are signed Q12.8. Canvas size and the
//  background character sit in APB registers at 0x0, 0x4 and 0x8; write
//  them only while no command is outstanding.
//  Each command gives one result: done pulses for one cycle with status and
//  pixel_char. The receiver cannot stall, so results are never held.
//  Clear and draw sweep the canvas one pixel per cycle, up to 256x256
//  pixels; the single frame-store write port sets the rate.
//  A two-entry command queue lets new commands be taken during a sweep;
//  busy rises when it is full.
//  Reset returns the registers to 256, 256 and 32 and drops queued work.
//  Frame contents are undefined until the first clear.
// ---------------------------------------------------------------------------
module rectangle_outline_fill_raster import rofr_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [APB_ADDR_W-1:0]     paddr,
	input  logic [APB_DATA_W-1:0]     pwdata,
	output logic [APB_DATA_W-1:0]     prdata,
	output logic                      pready,
	input  logic                      start,
	output logic                      busy,
	input  logic [1:0]                mode,
	input  logic signed [FIELD_W-1:0] rect_left,
	input  logic signed [FIELD_W-1:0] rect_top,
	input  logic signed [FIELD_W-1:0] rect_width,
	input  logic signed [FIELD_W-1:0] rect_height,
	input  logic                      filled,
	input  logic [CHAR_W-1:0]         paint_char,
	input  logic [PIX_W-1:0]          pixel_x,
	input  logic [PIX_W-1:0]          pixel_y,
	output logic                      done,
	output logic [1:0]                status,
	output logic [CHAR_W-1:0]         pixel_char
);

	canvas_cfg_t cfg;
	rofr_cmd_t   push_cmd;
	rofr_cmd_t   head;
	logic        push, pop, q_full, q_empty;

	rofr_front u_front (
		.clk, .arst_n,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.start, .busy, .mode,
		.rect_left, .rect_top, .rect_width, .rect_height,
		.filled, .paint_char, .pixel_x, .pixel_y,
		.q_full, .push, .push_cmd, .cfg
	);

	rofr_queue u_queue (
		.clk, .arst_n,
		.push, .push_cmd, .pop, .head,
		.full  (q_full),
		.empty (q_empty)
	);

	rofr_back u_back (
		.clk, .arst_n, .cfg, .q_empty, .head, .pop,
		.done, .status, .pixel_char
	);

endmodule

FILE: design/rofr_queue.sv
// ---------------------------------------------------------------------------
// rofr_queue
// Short command queue between the front and the back of the raster.
// ---------------------------------------------------------------------------
module rofr_queue import rofr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  rofr_cmd_t push_cmd,
	input  logic      pop,
	output rofr_cmd_t head,
	output logic      full,
	output logic      empty
);

	rofr_cmd_t           entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign head  = entry_q[rd_ptr_q];
	assign full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (32'(wr_ptr_q) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (32'(rd_ptr_q) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

FILE: design/rofr_front.sv
// ---------------------------------------------------------------------------
// rofr_front
// Register file and command intake: classifies each item and builds the
// edge and inset bounds the back end compares against.
// ---------------------------------------------------------------------------
module rofr_front import rofr_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [APB_ADDR_W-1:0]     paddr,
	input  logic [APB_DATA_W-1:0]     pwdata,
	output logic [APB_DATA_W-1:0]     prdata,
	output logic                      pready,
	input  logic                      start,
	output logic                      busy,
	input  logic [1:0]                mode,
	input  logic signed [FIELD_W-1:0] rect_left,
	input  logic signed [FIELD_W-1:0] rect_top,
	input  logic signed [FIELD_W-1:0] rect_width,
	input  logic signed [FIELD_W-1:0] rect_height,
	input  logic                      filled,
	input  logic [CHAR_W-1:0]         paint_char,
	input  logic [PIX_W-1:0]          pixel_x,
	input  logic [PIX_W-1:0]          pixel_y,
	input  logic                      q_full,
	output logic                      push,
	output rofr_cmd_t                 push_cmd,
	output canvas_cfg_t               cfg
);

	logic [CANVAS_W-1:0] canvas_w_q;
	logic [CANVAS_W-1:0] canvas_h_q;
	logic [CHAR_W-1:0]   bg_char_q;
	logic [1:0]          reg_idx;
	logic                reg_wr;
	logic [CMP_W-1:0]    last_col_w;
	logic [CMP_W-1:0]    last_row_w;
	logic signed [COORD_W-1:0] sl, st, sw, sh;
	logic                bad_size;
	logic                outside;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign reg_wr  = psel && penable && pwrite && pready;
	assign busy    = q_full;
	assign push    = start && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			canvas_w_q <= RST_CANVAS_W;
			canvas_h_q <= RST_CANVAS_H;
			bg_char_q  <= RST_BG_CHAR;
		end else if (reg_wr) begin
			unique case (reg_idx)
				REG_CANVAS_W: canvas_w_q <= pwdata[CANVAS_W-1:0];
				REG_CANVAS_H: canvas_h_q <= pwdata[CANVAS_W-1:0];
				REG_BG_CHAR:  bg_char_q  <= pwdata[CHAR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_CANVAS_W: prdata = APB_DATA_W'(canvas_w_q);
			REG_CANVAS_H: prdata = APB_DATA_W'(canvas_h_q);
			REG_BG_CHAR:  prdata = APB_DATA_W'(bg_char_q);
			default:      prdata = '0;
		endcase
	end

	assign last_col_w   = dim_last(canvas_w_q, MAX_COLUMNS);
	assign last_row_w   = dim_last(canvas_h_q, MAX_ROWS);
	assign cfg.last_col = last_col_w[COL_W-1:0];
	assign cfg.last_row = last_row_w[ROW_W-1:0];
	assign cfg.bg_char  = bg_char_q;

	assign sl = COORD_W'(rect_left);
	assign st = COORD_W'(rect_top);
	assign sw = COORD_W'(rect_width);
	assign sh = COORD_W'(rect_height);

	assign bad_size = rect_width[FIELD_W-1] || (rect_width == '0) ||
		rect_height[FIELD_W-1] || (rect_height == '0);
	assign outside = (CMP_W'(pixel_x) > last_col_w) || (CMP_W'(pixel_y) > last_row_w);

	always_comb begin
		push_cmd.x_lo    = sl;
		push_cmd.x_hi    = sl + sw;
		push_cmd.x_lo_in = sl + ONE_Q;
		push_cmd.x_hi_in = sl + sw - ONE_Q;
		push_cmd.y_lo    = st;
		push_cmd.y_hi    = st + sh;
		push_cmd.y_lo_in = st + ONE_Q;
		push_cmd.y_hi_in = st + sh - ONE_Q;
		push_cmd.full    = filled;
		push_cmd.paint   = paint_char;
		push_cmd.rd_x    = COL_W'(pixel_x);
		push_cmd.rd_y    = ROW_W'(pixel_y);
		push_cmd.op      = OP_NONE;
		push_cmd.status  = STAT_OK;
		unique case (mode)
			MODE_CLEAR: push_cmd.op = OP_CLEAR;
			MODE_DRAW: begin
				if (bad_size)
					push_cmd.status = STAT_BAD_SIZE;
				else
					push_cmd.op = OP_DRAW;
			end
			MODE_READ: begin
				if (outside)
					push_cmd.status = STAT_OUTSIDE;
				else
					push_cmd.op = OP_READ;
			end
			default: ;
		endcase
	end

endmodule

FILE: design/rofr_back.sv
// ---------------------------------------------------------------------------
// rofr_back
// Pixel sequencer and frame store: sweeps the canvas for clear and draw,
// reads single cells, and drives the result strobe.
// ---------------------------------------------------------------------------
module rofr_back import rofr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  canvas_cfg_t       cfg,
	input  logic              q_empty,
	input  rofr_cmd_t         head,
	output logic              pop,
	output logic              done,
	output logic [1:0]        status,
	output logic [CHAR_W-1:0] pixel_char
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SWEEP = 3'd1;
	localparam logic [2:0] ST_READ  = 3'd2;
	localparam logic [2:0] ST_RDOUT = 3'd3;
	localparam logic [2:0] ST_EMIT  = 3'd4;

	logic [2:0]          state_q;
	logic                done_q;
	logic [1:0]          status_q;
	logic [CHAR_W-1:0]   pixel_char_q;
	rofr_cmd_t           cmd_q;
	logic [COL_W-1:0]    x_q;
	logic [ROW_W-1:0]    y_q;
	logic [CHAR_W-1:0]   rd_data_q;
	logic [CHAR_W-1:0]   mem [MEM_DEPTH];

	logic signed [COORD_W-1:0] px, py;
	logic                in_x, in_y, inner_x, inner_y, hit;
	logic                we;
	logic [CHAR_W-1:0]   wdata;
	logic                last_px;

	assign pop        = (state_q == ST_IDLE) && !q_empty;
	assign done       = done_q;
	assign status     = status_q;
	assign pixel_char = pixel_char_q;

	assign px = $signed(COORD_W'({x_q, {FRAC_W{1'b0}}}));
	assign py = $signed(COORD_W'({y_q, {FRAC_W{1'b0}}}));

	assign in_x    = (px >= cmd_q.x_lo) && (px <= cmd_q.x_hi);
	assign in_y    = (py >= cmd_q.y_lo) && (py <= cmd_q.y_hi);
	assign inner_x = (px >= cmd_q.x_lo_in) && (px <= cmd_q.x_hi_in);
	assign inner_y = (py >= cmd_q.y_lo_in) && (py <= cmd_q.y_hi_in);
	assign hit     = in_x && in_y && (cmd_q.full || !(inner_x && inner_y));

	assign we      = (state_q == ST_SWEEP) && ((cmd_q.op == OP_CLEAR) || hit);
	assign wdata   = (cmd_q.op == OP_CLEAR) ? cfg.bg_char : cmd_q.paint;
	assign last_px = (x_q == cfg.last_col) && (y_q == cfg.last_row);

	always_ff @(posedge clk) begin
		if (we)
			mem[{y_q, x_q}] <= wdata;
		rd_data_q <= mem[{cmd_q.rd_y, cmd_q.rd_x}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						unique case (head.op) inside
							OP_CLEAR, OP_DRAW: state_q <= ST_SWEEP;
							OP_READ:           state_q <= ST_READ;
							default:           state_q <= ST_EMIT;
						endcase
					end
				end
				ST_SWEEP: begin
					if (last_px) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_READ:  state_q <= ST_RDOUT;
				ST_RDOUT: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_EMIT: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					cmd_q <= head;
					x_q   <= '0;
					y_q   <= '0;
				end
			end
			ST_SWEEP: begin
				if (last_px) begin
					status_q     <= STAT_OK;
					pixel_char_q <= '0;
				end else if (x_q == cfg.last_col) begin
					x_q <= '0;
					y_q <= y_q + 1'b1;
				end else begin
					x_q <= x_q + 1'b1;
				end
			end
			ST_READ: ;
			ST_RDOUT: begin
				status_q     <= cmd_q.status;
				pixel_char_q <= rd_data_q;
			end
			ST_EMIT: begin
				status_q     <= cmd_q.status;
				pixel_char_q <= '0;
			end
			default: ;
		endcase
	end

endmodule

FILE: design/rofr_checker.sv
// ---------------------------------------------------------------------------
// rofr_checker
// Port-level checks on the raster result strobe and the APB ready, bound to the top level.
// ---------------------------------------------------------------------------
`include "rectangle_outline_fill_raster_defines.svh"

module rofr_checker import rofr_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              pready,
	input logic              done,
	input logic [1:0]        status,
	input logic [CHAR_W-1:0] pixel_char
);

	`ROFR_ASSERT_NEXT(a_done_single, done, !done)
	`ROFR_ASSERT_NOW(a_status_code, done, status != 2'd3)
	`ROFR_ASSERT_NOW(a_err_no_pixel, done && (status != STAT_OK), pixel_char == '0)
	`ROFR_ASSERT_NOW(a_pready_high, 1'b1, pready)

endmodule

bind rectangle_outline_fill_raster rofr_checker u_rofr_checker (
	.clk, .arst_n, .pready, .done, .status, .pixel_char
);
